>>> src/sddf_pkg.sv
// Shared types, constants and helper functions for the six-digit display formatter.
// No dependencies; every other file in src imports this package.
package sddf_pkg;

	// Default number of display positions
	localparam int DIGIT_COUNT_DEF = 6;

	// Fixed field widths
	localparam int NUM_W      = 21;
	localparam int MASK_W     = 6;
	localparam int POS_W      = 3;
	localparam int GLYPH_W    = 4;

	// Binary to BCD conversion: 21 bits give at most 7 decimal digits
	localparam int BCD_DIGITS   = 7;
	localparam int BCD_W        = 4 * BCD_DIGITS;
	localparam int DABBLE_STEPS = 7;   // shift/add-3 steps per conversion stage

	// Glyph codes
	localparam logic [GLYPH_W-1:0] GLYPH_MINUS = 4'd10;

	// Input transaction
	typedef struct packed {
		logic signed [NUM_W-1:0] number;
		logic [MASK_W-1:0]       point_mask;
		logic                    align_right;
		logic                    show_zeros;
	} in_item_t;

	// Output transaction
	typedef struct packed {
		logic [POS_W-1:0]   position;
		logic [GLYPH_W-1:0] glyph;
		logic               point_on;
		logic               last_write;
	} out_item_t;

	// Per-item control that rides along the conversion pipeline
	typedef struct packed {
		logic              neg;
		logic [MASK_W-1:0] mask;
		logic              right;
		logic              zeros;
	} side_t;

	// 10^k, elaboration time only
	function automatic logic [31:0] pow10(input int k);
		logic [31:0] p;
		p = 32'd1;
		for (int i = 0; i < k; i++) begin
			p = p * 32'd10;
		end
		return p;
	endfunction

endpackage

>>> src/sddf_dabble.sv
// One stage of the binary to BCD converter: seven shift/add-3 steps, then a register.
// Depends on sddf_pkg.
module sddf_dabble (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	output logic                       in_rdy,
	input  logic [sddf_pkg::BCD_W-1:0] in_bcd,
	input  logic [sddf_pkg::NUM_W-1:0] in_bin,
	input  sddf_pkg::side_t            in_side,
	output logic                       out_vld,
	input  logic                       out_rdy,
	output logic [sddf_pkg::BCD_W-1:0] out_bcd,
	output logic [sddf_pkg::NUM_W-1:0] out_bin,
	output sddf_pkg::side_t            out_side
);
	import sddf_pkg::*;

	logic             vld_s1;
	logic [BCD_W-1:0] bcd_s1;
	logic [NUM_W-1:0] bin_s1;
	side_t            side_s1;

	logic [BCD_W-1:0] bcd_nx;
	logic [NUM_W-1:0] bin_nx;

	// Adjust each digit >= 5 by 3, then shift one binary bit in
	always_comb begin
		bcd_nx = in_bcd;
		bin_nx = in_bin;
		for (int s = 0; s < DABBLE_STEPS; s++) begin
			for (int d = 0; d < BCD_DIGITS; d++) begin
				if (bcd_nx[4*d +: 4] >= 4'd5) begin
					bcd_nx[4*d +: 4] = bcd_nx[4*d +: 4] + 4'd3;
				end
			end
			{bcd_nx, bin_nx} = {bcd_nx, bin_nx} << 1;
		end
	end

	assign in_rdy = !vld_s1 || out_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (in_rdy) begin
			vld_s1 <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (in_rdy && in_vld) begin
			bcd_s1  <= bcd_nx;
			bin_s1  <= bin_nx;
			side_s1 <= in_side;
		end
	end

	assign out_vld  = vld_s1;
	assign out_bcd  = bcd_s1;
	assign out_bin  = bin_s1;
	assign out_side = side_s1;

endmodule

>>> src/sddf_emit.sv
// Layout and glyph sequencer: works out digit count and start position, then
// issues one glyph write per cycle into the output register while out_ready allows it. Depends on sddf_pkg.
module sddf_emit #(
	parameter int DIGIT_COUNT = sddf_pkg::DIGIT_COUNT_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_vld,
	output logic                       in_rdy,
	input  logic [sddf_pkg::BCD_W-1:0] in_bcd,
	input  sddf_pkg::side_t            in_side,
	output logic                       out_valid,
	input  logic                       out_ready,
	output sddf_pkg::out_item_t        out_item
);
	import sddf_pkg::*;

	localparam int PAD   = (DIGIT_COUNT > BCD_DIGITS) ? DIGIT_COUNT : BCD_DIGITS;
	localparam int CNT_W = $clog2(DIGIT_COUNT + 1);

	logic [4*PAD-1:0]         digits_pad;
	logic [CNT_W-1:0]         sig_cnt;
	logic [CNT_W-1:0]         width;
	logic [CNT_W-1:0]         nd;
	logic [CNT_W-1:0]         start;

	logic                     busy_q;
	logic [4*DIGIT_COUNT-1:0] dig_q;
	logic [MASK_W-1:0]        mask_q;
	logic [POS_W-1:0]         pos_q;
	logic [CNT_W-1:0]         rem_q;
	logic                     neg_q;

	logic                     out_vld_q;
	out_item_t                out_q;

	logic                     emit;
	logic                     last;
	logic                     take;

	// Significant digit count (zero counts as one digit) and field layout
	always_comb begin
		digits_pad = (4*PAD)'(in_bcd);
		sig_cnt    = CNT_W'(1);
		for (int d = 1; d < DIGIT_COUNT; d++) begin
			if (digits_pad[4*d +: 4] != 4'd0) begin
				sig_cnt = CNT_W'(d + 1);
			end
		end
		width = in_side.neg ? CNT_W'(DIGIT_COUNT - 1) : CNT_W'(DIGIT_COUNT);
		nd    = (in_side.right && in_side.zeros) ? width : sig_cnt;
		start = in_side.right ? '0 : width - nd;
	end

	// Sequencer handshake
	assign last   = neg_q ? (rem_q == '0) : (rem_q == CNT_W'(1));
	assign emit   = busy_q && (!out_vld_q || out_ready);
	assign in_rdy = !busy_q || (emit && last);
	assign take   = in_vld && in_rdy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (take) begin
				busy_q <= 1'b1;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Item registers: load a new transaction or step to the next glyph
	always_ff @(posedge clk) begin
		if (take) begin
			dig_q  <= digits_pad[4*DIGIT_COUNT-1:0];
			mask_q <= in_side.mask;
			pos_q  <= POS_W'(start);
			rem_q  <= nd;
			neg_q  <= in_side.neg;
		end else if (emit) begin
			dig_q  <= dig_q >> 4;
			mask_q <= mask_q >> 1;
			pos_q  <= pos_q + POS_W'(1);
			if (rem_q != '0) begin
				rem_q <= rem_q - CNT_W'(1);
			end
		end
	end

	// Output register
	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.position   <= pos_q;
			out_q.glyph      <= (rem_q != '0) ? dig_q[3:0] : GLYPH_MINUS;
			out_q.point_on   <= mask_q[0];
			out_q.last_write <= last;
		end
	end

	assign out_valid = out_vld_q;
	assign out_item  = out_q;

endmodule

>>> src/six_digit_number_display_formatter.sv
// Six-digit number display formatter: turns a signed number into glyph writes for a
// seven-segment display. Depends on sddf_pkg, sddf_dabble and sddf_emit.
//
// Each accepted transaction carries a number, a decimal-point mask and two layout
// flags; the block answers with one write per glyph (digits least significant first,
// then the minus sign), last_write marking the final one, and nothing at all for a
// number outside the displayable range. The number passes a range/sign stage, a
// three-stage binary to BCD converter (seven shift/add-3 steps per stage), the
// sequencer's item registers and the output register. The glyph sequencer issues
// one write per cycle while out_ready allows; a number yields nd + neg writes (1 to
// DIGIT_COUNT, 6 with the default); the sequencer sets the sustained rate, while the
// converter stages take a new number every cycle and hold it under back-pressure.
module six_digit_number_display_formatter #(
	parameter int DIGIT_COUNT = sddf_pkg::DIGIT_COUNT_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sddf_pkg::in_item_t  in_item,
	output logic                out_valid,
	input  logic                out_ready,
	output sddf_pkg::out_item_t out_item
);
	import sddf_pkg::*;

	localparam logic [31:0] HI     = pow10(DIGIT_COUNT) - 32'd1;
	localparam logic [31:0] LO_MAG = pow10(DIGIT_COUNT - 1) - 32'd1;

	logic             neg;
	logic [NUM_W-1:0] mag_neg;
	logic [NUM_W-1:0] mag;
	logic             in_range;

	logic             vld_s1;
	logic [NUM_W-1:0] mag_s1;
	side_t            side_s1;
	side_t            side_in;
	logic             rdy_s1;

	logic             vld_s2, vld_s3, vld_s4;
	logic             rdy_s2, rdy_s3, rdy_s4;
	logic [BCD_W-1:0] bcd_s2, bcd_s3, bcd_s4;
	logic [NUM_W-1:0] bin_s2, bin_s3, bin_s4;
	side_t            side_s2, side_s3, side_s4;

	// Range check and magnitude
	always_comb begin
		neg     = in_item.number[NUM_W-1];
		mag_neg = ~$unsigned(in_item.number) + NUM_W'(1);
		mag     = neg ? mag_neg : {1'b0, in_item.number[NUM_W-2:0]};
		in_range = neg ? ({{(32-NUM_W){1'b0}}, mag} <= LO_MAG)
		               : ({{(32-NUM_W){1'b0}}, mag} <= HI);
		side_in.neg   = neg;
		side_in.mask  = in_item.point_mask;
		side_in.right = in_item.align_right;
		side_in.zeros = in_item.show_zeros;
	end

	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign in_ready = rdy_s1;

	// Out-of-range numbers are accepted and dropped here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (rdy_s1) begin
			vld_s1 <= in_valid && in_range;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && in_valid) begin
			mag_s1  <= mag;
			side_s1 <= side_in;
		end
	end

	// Binary to BCD, three stages
	sddf_dabble u_dabble_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s1),
		.in_rdy   (rdy_s2),
		.in_bcd   ('0),
		.in_bin   (mag_s1),
		.in_side  (side_s1),
		.out_vld  (vld_s2),
		.out_rdy  (rdy_s3),
		.out_bcd  (bcd_s2),
		.out_bin  (bin_s2),
		.out_side (side_s2)
	);

	sddf_dabble u_dabble_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s2),
		.in_rdy   (rdy_s3),
		.in_bcd   (bcd_s2),
		.in_bin   (bin_s2),
		.in_side  (side_s2),
		.out_vld  (vld_s3),
		.out_rdy  (rdy_s4),
		.out_bcd  (bcd_s3),
		.out_bin  (bin_s3),
		.out_side (side_s3)
	);

	logic rdy_emit;

	sddf_dabble u_dabble_c (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_s3),
		.in_rdy   (rdy_s4),
		.in_bcd   (bcd_s3),
		.in_bin   (bin_s3),
		.in_side  (side_s3),
		.out_vld  (vld_s4),
		.out_rdy  (rdy_emit),
		.out_bcd  (bcd_s4),
		.out_bin  (bin_s4),
		.out_side (side_s4)
	);

	// Layout and glyph sequencing; the residual binary bits are all shifted out
	sddf_emit #(
		.DIGIT_COUNT (DIGIT_COUNT)
	) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_vld    (vld_s4 && (bin_s4 == '0 || bin_s4 != '0)),
		.in_rdy    (rdy_emit),
		.in_bcd    (bcd_s4),
		.in_side   (side_s4),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

>>> verif/six_digit_number_display_formatter_test.sv
// Self-checking testbench for six_digit_number_display_formatter: a directed table, then random
// numbers under several sender/receiver idling mixes and one long receiver hold-off.
// Depends on sddf_pkg and the formatter RTL only.
module six_digit_number_display_formatter_test;
	timeunit 1ns;
	timeprecision 1ps;

	import sddf_pkg::*;

	localparam int DIGITS       = DIGIT_COUNT_DEF;
	localparam int FIELD_MAX    = 10 ** DIGITS - 1;
	localparam int FIELD_MIN    = -(10 ** (DIGITS - 1) - 1);
	localparam int BY_MODEL     = -1;      // directed row checked against the predictor
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 24;
	localparam int HOLD_CYCLES  = 400;
	localparam int RAND_PER_MIX = 40;
	localparam int PRESSURE_NUM = 30;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_item   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_item;

	// idling controls, set by the stimulus process
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int hold_off_len   = 0;

	// directed table and the hand-written writes of its typed rows
	in_item_t  table_items[$];
	int        table_typed[$];
	out_item_t typed_writes_q[$];

	// per offered number: BY_MODEL or the count of typed writes
	int        number_kind_q[$];
	// glyph writes still owed by the block, oldest first
	out_item_t writes_due[$];

	int numbers_taken  = 0;
	int numbers_blank  = 0;
	int writes_checked = 0;
	int mismatches     = 0;

	six_digit_number_display_formatter #(
		.DIGIT_COUNT(DIGITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_item (out_item)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Work out the glyph writes one number should cause and queue them
	function automatic void predict_writes(input in_item_t it);
		int          value;
		int unsigned mag;
		int unsigned scan;
		int          width;
		int          nd;
		int          base;
		logic [5:0]  pts;
		logic        neg;
		out_item_t   w;
		int          first;

		value = int'(it.number);
		pts   = it.point_mask;
		if (value >= 0 && value <= FIELD_MAX) begin
			mag   = value;
			width = DIGITS;
			neg   = 1'b0;
		end else if (value < 0 && value >= FIELD_MIN) begin
			mag   = -value;
			width = DIGITS - 1;
			neg   = 1'b1;
		end else begin
			numbers_blank++;
			return;
		end

		// significant digits; zero still takes one position
		nd = 1;
		for (scan = mag; scan >= 10; scan = scan / 10)
			nd++;
		if (it.align_right && it.show_zeros)
			nd = width;
		base  = it.align_right ? 0 : width - nd;
		first = writes_due.size();

		for (int i = 0; i < nd; i++) begin
			w.position   = POS_W'(base + i);
			w.glyph      = GLYPH_W'(mag % 10);
			w.point_on   = pts[0];
			w.last_write = 1'b0;
			writes_due.push_back(w);
			mag = mag / 10;
			pts = pts >> 1;
		end
		if (neg) begin
			w.position   = POS_W'(base + nd);
			w.glyph      = GLYPH_MINUS;
			w.point_on   = pts[0];
			w.last_write = 1'b0;
			writes_due.push_back(w);
		end
		if (writes_due.size() > first)
			writes_due[writes_due.size() - 1].last_write = 1'b1;
	endfunction

	task automatic add_row(input int value, input int mask, input int right, input int zeros,
			input int n_typed);
		in_item_t it;
		it.number      = NUM_W'(value);
		it.point_mask  = MASK_W'(mask);
		it.align_right = 1'(right);
		it.show_zeros  = 1'(zeros);
		table_items.push_back(it);
		table_typed.push_back(n_typed);
	endtask

	task automatic add_write(input int pos, input int glyph, input int pt, input int last);
		out_item_t w;
		w.position   = POS_W'(pos);
		w.glyph      = GLYPH_W'(glyph);
		w.point_on   = 1'(pt);
		w.last_write = 1'(last);
		typed_writes_q.push_back(w);
	endtask

	// Random number: mostly well-formed values of every digit count, some raw noise
	function automatic in_item_t random_number_item();
		in_item_t it;
		int       sel;
		int       nd;
		int       mag;
		bit       neg;

		sel            = $urandom_range(99);
		it.point_mask  = MASK_W'($urandom);
		it.align_right = 1'($urandom_range(1));
		it.show_zeros  = 1'($urandom_range(1));
		if (sel < 10) begin
			it.number = NUM_W'($urandom);
		end else begin
			neg       = (sel < 45);
			nd        = $urandom_range(neg ? DIGITS - 1 : DIGITS, 1);
			mag       = $urandom_range(10 ** nd - 1, (nd == 1) ? 0 : 10 ** (nd - 1));
			it.number = NUM_W'(neg ? -mag : mag);
		end
		return it;
	endfunction

	// Offer one number; returns at the edge where it was accepted
	task automatic send_number(input in_item_t it, input int n_typed);
		while (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		number_kind_q.push_back(n_typed);
		in_valid <= 1'b1;
		in_item  <= it;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	// Receiver: random stalls, plus a long hold-off on request
	initial begin : receiver
		int held;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_len > 0) begin
				out_ready <= 1'b0;
				for (held = 0; held < hold_off_len; held++)
					@(posedge clk);
				hold_off_len = 0;
			end else begin
				out_ready <= ($urandom_range(99) < sink_stall_pct) ? 1'b0 : 1'b1;
			end
		end
	end

	// Scoreboard: expectations on input transactions, checks on output transactions
	always @(posedge clk) begin : scoreboard
		int        n_typed;
		out_item_t want;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				n_typed = number_kind_q.pop_front();
				numbers_taken++;
				if (n_typed == BY_MODEL)
					predict_writes(in_item);
				else if (n_typed == 0)
					numbers_blank++;
				else
					repeat (n_typed) writes_due.push_back(typed_writes_q.pop_front());
			end
			if (out_valid && out_ready) begin
				writes_checked++;
				if (writes_due.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected write: pos %0d glyph %0d point %0d last %0d",
							out_item.position, out_item.glyph, out_item.point_on,
							out_item.last_write);
				end else begin
					want = writes_due.pop_front();
					if (want.position !== out_item.position || want.glyph !== out_item.glyph ||
							want.point_on !== out_item.point_on ||
							want.last_write !== out_item.last_write) begin
						mismatches++;
						if (mismatches <= 10)
							$display("write mismatch: expected pos %0d glyph %0d point %0d last %0d, got pos %0d glyph %0d point %0d last %0d",
								want.position, want.glyph, want.point_on, want.last_write,
								out_item.position, out_item.glyph, out_item.point_on,
								out_item.last_write);
					end
				end
			end
		end
	end

	// Watchdog
	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("six_digit_number_display_formatter regression: fail");
		$finish;
	end

	initial begin : stimulus
		int src_mix[4];
		int sink_mix[4];

		src_mix  = '{0, 53, 0, 21};
		sink_mix = '{0, 0, 53, 21};

		// directed table: extremes, range edges, layouts and point masks
		add_row(0, 0, 1, 0, 1);
		add_write(0, 0, 0, 1);
		add_row(0, 1, 0, 0, 1);
		add_write(DIGITS - 1, 0, 1, 1);
		add_row(0, 0, 1, 1, BY_MODEL);
		add_row(FIELD_MAX, 63, 1, 1, DIGITS);
		for (int i = 0; i < DIGITS; i++)
			add_write(i, 9, 1, int'(i == DIGITS - 1));
		add_row(FIELD_MAX, 0, 0, 0, BY_MODEL);
		add_row(FIELD_MAX + 1, 63, 1, 1, 0);
		add_row(FIELD_MIN, 63, 1, 1, BY_MODEL);
		add_row(FIELD_MIN, 21, 0, 0, BY_MODEL);
		add_row(FIELD_MIN - 1, 63, 0, 1, 0);
		add_row(-1, 0, 1, 0, 2);
		add_write(0, 1, 0, 0);
		add_write(1, int'(GLYPH_MINUS), 0, 1);
		add_row(-1, 3, 0, 0, BY_MODEL);
		add_row(-1, 32, 1, 1, BY_MODEL);
		add_row(1048575, 63, 1, 0, 0);
		add_row(-1048576, 63, 0, 0, 0);
		add_row(12345, 42, 0, 1, BY_MODEL);
		add_row(12345, 21, 1, 0, BY_MODEL);
		add_row(7, 63, 1, 1, BY_MODEL);
		add_row(-42, 42, 0, 1, BY_MODEL);
		add_row(100000, 0, 1, 0, BY_MODEL);
		add_row(-10, 4, 1, 0, BY_MODEL);
		add_row(-99, 63, 1, 1, BY_MODEL);

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (table_items[i])
			send_number(table_items[i], table_typed[i]);

		// random numbers under each idling mix
		for (int m = 0; m < 4; m++) begin
			src_idle_pct   = src_mix[m];
			sink_stall_pct = sink_mix[m];
			repeat (RAND_PER_MIX) send_number(random_number_item(), BY_MODEL);
		end

		// back-pressure: receiver holds off while numbers keep coming
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		hold_off_len   = HOLD_CYCLES;
		repeat (PRESSURE_NUM) send_number(random_number_item(), BY_MODEL);
		in_valid <= 1'b0;

		while (writes_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d numbers (%0d from the table, %0d outside the display range)",
			numbers_taken, table_items.size(), numbers_blank);
		$display("checked %0d glyph writes across four idling mixes and one long hold-off",
			writes_checked);
		if (mismatches == 0 && writes_due.size() == 0) begin
			$display("six_digit_number_display_formatter regression: pass");
		end else begin
			$display("%0d mismatches, %0d writes still owed", mismatches, writes_due.size());
			$display("six_digit_number_display_formatter regression: fail");
		end
		$finish;
	end

endmodule

>>> six_digit_number_display_formatter.f
src/sddf_pkg.sv
src/sddf_dabble.sv
src/sddf_emit.sv
src/six_digit_number_display_formatter.sv
verif/six_digit_number_display_formatter_test.sv
